[rtl/core/line_follow_pd_steering_core_macros.svh]
// Assertion macros shared by the steering core RTL.
`ifndef LINE_FOLLOW_PD_STEERING_CORE_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LFPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfpd assertion failed");
`define LFPD_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lfpd forbidden condition");
`else
`define LFPD_ASSERT(label, prop)
`define LFPD_NEVER(label, expr)
`endif
`endif

[rtl/core/lfpd_pkg.sv]
// Shared widths, constants and register codes of the steering core.
package lfpd_pkg;
  localparam int unsigned LevelW   = 10;
  localparam int unsigned GainW    = 10;
  localparam int unsigned DriveW   = 15;
  localparam int unsigned NormW    = 10;
  localparam int unsigned ErrW     = 12;
  localparam int unsigned CorrW    = 25;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [NormW-1:0]         NormFull    = 10'd1000;
  localparam logic [NormW-1:0]         LostLevel   = 10'd300;
  localparam logic signed [ErrW-1:0]   RecoverErr  = 12'sd700;
  localparam logic [DriveW-1:0]        DriveMax    = 15'd30000;
  localparam logic [DriveW-1:0]        CruiseReset = 15'd9000;
  localparam logic [LevelW-1:0]        WhiteReset  = 10'd0;
  localparam logic [LevelW-1:0]        BlackReset  = 10'd1023;
  localparam logic [GainW-1:0]         KpReset     = 10'd8;
  localparam logic [GainW-1:0]         KdReset     = 10'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHITE_L,
    CFG_BLACK_L,
    CFG_WHITE_R,
    CFG_BLACK_R,
    CFG_KP,
    CFG_KD,
    CFG_CRUISE
  } cfg_idx_e;
endpackage

[rtl/core/lfpd_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module lfpd_div #(
  parameter int unsigned NumW = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NumW-1:0]             dividend_i,
  input  logic [lfpd_pkg::LevelW-1:0] divisor_i,
  output logic [NumW-1:0]             quotient_o,
  output logic                        busy_o,
  output logic                        done_o
);
  localparam int unsigned DW   = lfpd_pkg::LevelW;
  localparam int unsigned CntW = (NumW > 1) ? $clog2(NumW) : 1;

  logic [NumW-1:0] dvd_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     trial, diff;
  logic            fits;

  assign trial = {rem_q, dvd_q[NumW-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
        dvd_q <= {dvd_q[NumW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = dvd_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;
endmodule

[rtl/core/lfpd_mac.sv]
// Serial shift-add unit: err*kp + deriv*kd, one gain bit per cycle.
module lfpd_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [lfpd_pkg::ErrW-1:0]  err_i,
  input  logic signed [lfpd_pkg::ErrW-1:0]  deriv_i,
  input  logic [lfpd_pkg::GainW-1:0]        kp_i,
  input  logic [lfpd_pkg::GainW-1:0]        kd_i,
  output logic signed [lfpd_pkg::CorrW-1:0] corr_o,
  output logic                              busy_o,
  output logic                              done_o
);
  localparam int unsigned GW   = lfpd_pkg::GainW;
  localparam int unsigned CW   = lfpd_pkg::CorrW;
  localparam int unsigned CntW = $clog2(2 * GW);

  logic signed [CW-1:0]             acc_q, mcand_q;
  logic signed [lfpd_pkg::ErrW-1:0] deriv_q;
  logic [GW-1:0]                    mult_q, kd_q;
  logic [CntW-1:0]                  cnt_q;
  logic                             busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      mcand_q <= '0;
      deriv_q <= '0;
      mult_q  <= '0;
      kd_q    <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q   <= '0;
        mcand_q <= CW'(err_i);
        mult_q  <= kp_i;
        deriv_q <= deriv_i;
        kd_q    <= kd_i;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        if (mult_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(GW - 1)) begin
          // second product: switch to the derivative term
          mcand_q <= CW'(deriv_q);
          mult_q  <= kd_q;
        end else begin
          mcand_q <= mcand_q <<< 1;
          mult_q  <= mult_q >> 1;
        end
        if (cnt_q == CntW'(2 * GW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign corr_o = acc_q;
  assign busy_o = busy_q;
  assign done_o = done_q;
endmodule

[rtl/core/line_follow_pd_steering_core.sv]
// Top level of the line-follow PD steering core.
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one beat carries a raw left and
//    right reflectance sample. Samples are taken only while the core is idle.
//  - Output channel (out_valid_o / out_stall_i): one beat per input beat,
//    carrying the left and right wheel drive values, 0..30000.
//  - Config channel (cfg_valid_i / cfg_ready_o): register index and data;
//    always ready. Write only while no item is in flight.
//  - Flow: both sides divide in parallel in bit-serial dividers of NumW
//    bits, where NumW = max(SAMPLE_BITS-2, 10) + 10, then one shift-add
//    unit forms the PD correction.
//  - Throughput: one item at a time; the next input beat is taken as soon
//    as the previous result is in the output register, even while stalled.
//  - Receiver stall: the result holds in the output register; a finished
//    following item waits in its last step until the register frees.
//  - Reset: registers return to their defaults, error history clears to 0.
`include "line_follow_pd_steering_core_macros.svh"
module line_follow_pd_steering_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lfpd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lfpd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [SAMPLE_BITS-1:0]              left_sample_i,
  input  logic [SAMPLE_BITS-1:0]              right_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lfpd_pkg::DriveW-1:0]         left_drive_o,
  output logic [lfpd_pkg::DriveW-1:0]         right_drive_o
);
  localparam int unsigned LW   = lfpd_pkg::LevelW;
  localparam int unsigned GW   = lfpd_pkg::GainW;
  localparam int unsigned DRW  = lfpd_pkg::DriveW;
  localparam int unsigned NRW  = lfpd_pkg::NormW;
  localparam int unsigned EW   = lfpd_pkg::ErrW;
  localparam int unsigned CW   = lfpd_pkg::CorrW;
  localparam int unsigned ScW  = SAMPLE_BITS - 2;
  localparam int unsigned MagW = (ScW > LW) ? ScW : LW;
  localparam int unsigned NumW = MagW + 10;  // x1000 < 2^10

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_ERR, S_MAC, S_OUT} state_e;

  state_e state_q;

  // configuration registers
  logic [LW-1:0]  white_l_q, black_l_q, white_r_q, black_r_q;
  logic [GW-1:0]  kp_q, kd_q;
  logic [DRW-1:0] cruise_q;

  // item registers
  logic [SAMPLE_BITS-1:0] lsamp_q, rsamp_q;
  logic [NumW-1:0]        l_num_q, r_num_q;
  logic [LW-1:0]          l_den_q, r_den_q;
  logic                   l_neg_q, r_neg_q, l_zero_q, r_zero_q;
  logic                   div_start_q, mac_start_q;
  logic signed [EW-1:0]   err_q, deriv_q;
  logic signed [EW-1:0]   rec_err_q, prior_err_q, prior_diff_q;
  logic                   out_valid_q;
  logic [DRW-1:0]         left_drive_q, right_drive_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_l_q <= lfpd_pkg::WhiteReset;
      black_l_q <= lfpd_pkg::BlackReset;
      white_r_q <= lfpd_pkg::WhiteReset;
      black_r_q <= lfpd_pkg::BlackReset;
      kp_q      <= lfpd_pkg::KpReset;
      kd_q      <= lfpd_pkg::KdReset;
      cruise_q  <= lfpd_pkg::CruiseReset;
    end else if (cfg_valid_i) begin
      case (lfpd_pkg::cfg_idx_e'(cfg_index_i))
        lfpd_pkg::CFG_WHITE_L: white_l_q <= cfg_data_i[LW-1:0];
        lfpd_pkg::CFG_BLACK_L: black_l_q <= cfg_data_i[LW-1:0];
        lfpd_pkg::CFG_WHITE_R: white_r_q <= cfg_data_i[LW-1:0];
        lfpd_pkg::CFG_BLACK_R: black_r_q <= cfg_data_i[LW-1:0];
        lfpd_pkg::CFG_KP:      kp_q      <= cfg_data_i[GW-1:0];
        lfpd_pkg::CFG_KD:      kd_q      <= cfg_data_i[GW-1:0];
        lfpd_pkg::CFG_CRUISE:  cruise_q  <= cfg_data_i[DRW-1:0];
        default: ;
      endcase
    end
  end

  // ---- normalization prep: |scaled - white| * 1000 and |black - white|
  logic signed [MagW:0] l_sd, r_sd;
  logic [MagW-1:0]      l_mag, r_mag;
  logic [NumW-1:0]      l_num, r_num;
  logic signed [LW:0]   l_den, r_den;

  assign l_sd  = $signed((MagW+1)'(lsamp_q[SAMPLE_BITS-1:2]))
               - $signed((MagW+1)'(white_l_q));
  assign r_sd  = $signed((MagW+1)'(rsamp_q[SAMPLE_BITS-1:2]))
               - $signed((MagW+1)'(white_r_q));
  assign l_mag = l_sd[MagW] ? MagW'(-l_sd) : l_sd[MagW-1:0];
  assign r_mag = r_sd[MagW] ? MagW'(-r_sd) : r_sd[MagW-1:0];
  // 1000 = 1024 - 16 - 8
  assign l_num = (NumW'(l_mag) << 10) - (NumW'(l_mag) << 4) - (NumW'(l_mag) << 3);
  assign r_num = (NumW'(r_mag) << 10) - (NumW'(r_mag) << 4) - (NumW'(r_mag) << 3);
  assign l_den = $signed({1'b0, black_l_q}) - $signed({1'b0, white_l_q});
  assign r_den = $signed({1'b0, black_r_q}) - $signed({1'b0, white_r_q});

  // ---- dividers, one per side
  logic [NumW-1:0] l_quo, r_quo;
  logic            l_busy, r_busy, l_done, r_done;

  lfpd_div #(.NumW(NumW)) u_div_l (
    .clk_i, .rst_ni, .start_i(div_start_q), .dividend_i(l_num_q),
    .divisor_i(l_den_q), .quotient_o(l_quo), .busy_o(l_busy), .done_o(l_done)
  );
  lfpd_div #(.NumW(NumW)) u_div_r (
    .clk_i, .rst_ni, .start_i(div_start_q), .dividend_i(r_num_q),
    .divisor_i(r_den_q), .quotient_o(r_quo), .busy_o(r_busy), .done_o(r_done)
  );

  // ---- error, line-lost recovery, averaged derivative
  logic [NRW-1:0]       ln, rn;
  logic signed [EW-1:0] err_raw, err_sel, diff;
  logic signed [EW:0]   dsum, dsum_adj;
  logic                 lost;

  assign ln = (l_zero_q || l_neg_q) ? '0 :
              (l_quo > NumW'(lfpd_pkg::NormFull)) ? lfpd_pkg::NormFull : l_quo[NRW-1:0];
  assign rn = (r_zero_q || r_neg_q) ? '0 :
              (r_quo > NumW'(lfpd_pkg::NormFull)) ? lfpd_pkg::NormFull : r_quo[NRW-1:0];
  assign err_raw = $signed(EW'(ln)) - $signed(EW'(rn));
  assign lost    = (ln < lfpd_pkg::LostLevel) && (rn < lfpd_pkg::LostLevel);
  assign err_sel = !lost ? err_raw :
                   (rec_err_q > 0) ? lfpd_pkg::RecoverErr : -lfpd_pkg::RecoverErr;
  assign diff     = err_sel - prior_err_q;
  assign dsum     = (EW+1)'(diff) + (EW+1)'(prior_diff_q);
  // halve toward zero: bias negatives by one before the shift
  assign dsum_adj = dsum + $signed((EW+1)'(dsum[EW]));

  // ---- correction
  logic signed [CW-1:0] corr;
  logic                 mac_busy, mac_done;

  lfpd_mac u_mac (
    .clk_i, .rst_ni, .start_i(mac_start_q), .err_i(err_q), .deriv_i(deriv_q),
    .kp_i(kp_q), .kd_i(kd_q), .corr_o(corr), .busy_o(mac_busy), .done_o(mac_done)
  );

  function automatic logic [DRW-1:0] clamp_drive(logic signed [CW:0] v);
    logic [DRW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed((CW+1)'(lfpd_pkg::DriveMax))) begin
      r = lfpd_pkg::DriveMax;
    end else begin
      r = v[DRW-1:0];
    end
    return r;
  endfunction

  logic signed [CW:0] base, corr_e, ls, rs;
  logic               corr_pos;

  assign base     = $signed((CW+1)'(cruise_q));
  assign corr_e   = (CW+1)'(corr);
  assign corr_pos = !corr[CW-1] && (corr != '0);
  assign ls       = corr_pos ? base - corr_e : base;
  assign rs       = corr_pos ? base : base + corr_e;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lsamp_q       <= '0;
      rsamp_q       <= '0;
      l_num_q       <= '0;
      r_num_q       <= '0;
      l_den_q       <= '0;
      r_den_q       <= '0;
      l_neg_q       <= 1'b0;
      r_neg_q       <= 1'b0;
      l_zero_q      <= 1'b0;
      r_zero_q      <= 1'b0;
      div_start_q   <= 1'b0;
      mac_start_q   <= 1'b0;
      err_q         <= '0;
      deriv_q       <= '0;
      rec_err_q     <= '0;
      prior_err_q   <= '0;
      prior_diff_q  <= '0;
      out_valid_q   <= 1'b0;
      left_drive_q  <= '0;
      right_drive_q <= '0;
    end else begin
      div_start_q <= 1'b0;
      mac_start_q <= 1'b0;
      // in the final step a taken beat is replaced by the next one below
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            lsamp_q <= left_sample_i;
            rsamp_q <= right_sample_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          l_num_q     <= l_num;
          r_num_q     <= r_num;
          l_den_q     <= l_den[LW] ? LW'(-l_den) : l_den[LW-1:0];
          r_den_q     <= r_den[LW] ? LW'(-r_den) : r_den[LW-1:0];
          l_neg_q     <= l_sd[MagW] ^ l_den[LW];
          r_neg_q     <= r_sd[MagW] ^ r_den[LW];
          l_zero_q    <= (l_den == '0);
          r_zero_q    <= (r_den == '0);
          div_start_q <= 1'b1;
          state_q     <= S_DIV;
        end
        S_DIV: begin
          if (l_done) begin
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          err_q        <= err_sel;
          deriv_q      <= dsum_adj[EW:1];
          prior_err_q  <= err_sel;
          prior_diff_q <= diff;
          if (!lost) begin
            rec_err_q <= err_raw;
          end
          mac_start_q <= 1'b1;
          state_q     <= S_MAC;
        end
        S_MAC: begin
          if (mac_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            left_drive_q  <= clamp_drive(ls);
            right_drive_q <= clamp_drive(rs);
            out_valid_q   <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_drive_q;
  assign right_drive_o = right_drive_q;

  // ---- checks
  `LFPD_ASSERT(a_out_from_final, $rose(out_valid_o) |-> $past(state_q == S_OUT))
  `LFPD_NEVER(a_units_overlap, mac_busy && (l_busy || r_busy))
  `LFPD_ASSERT(a_div_lockstep, l_done == r_done)
  `LFPD_ASSERT(a_hold_final, (state_q == S_OUT && out_valid_q && out_stall_i) |=> state_q == S_OUT)
endmodule

[test/lfpd_scoreboard.sv]
// Checker for the steering core: predicts drive beats and compares them.
`timescale 1ns / 1ps
module lfpd_scoreboard #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [lfpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lfpd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [SAMPLE_BITS-1:0]         left_sample_i,
  input  logic [SAMPLE_BITS-1:0]         right_sample_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [lfpd_pkg::DriveW-1:0]    left_drive_i,
  input  logic [lfpd_pkg::DriveW-1:0]    right_drive_i,
  output int                             pending_o,
  output int                             errors_o,
  output int                             lost_count_o
);
  localparam int unsigned DriveW = lfpd_pkg::DriveW;
  localparam int unsigned LevelW = lfpd_pkg::LevelW;
  localparam int unsigned GainW  = lfpd_pkg::GainW;
  localparam int unsigned ErrW   = lfpd_pkg::ErrW;

  typedef struct packed {
    logic [DriveW-1:0] left;
    logic [DriveW-1:0] right;
  } drive_pair_t;

  drive_pair_t       drive_q[$];
  logic [LevelW-1:0] white_l, black_l, white_r, black_r;
  logic [GainW-1:0]  kp, kd;
  logic [DriveW-1:0] cruise;
  logic signed [ErrW-1:0] last_seen_err, last_err, last_diff;

  assign pending_o = drive_q.size();

  task automatic report(input string msg);
    $display("[%0t] %s", $realtime, msg);
    errors_o++;
  endtask

  function automatic int norm_side(input logic [SAMPLE_BITS-1:0] raw,
                                   input logic [LevelW-1:0] white,
                                   input logic [LevelW-1:0] black);
    int scaled, den, v;
    scaled = int'(raw >> 2);
    den    = int'(black) - int'(white);
    if (den == 0) return 0;
    v = ((scaled - int'(white)) * 1000) / den;
    if (v < 0) v = 0;
    if (v > 1000) v = 1000;
    return v;
  endfunction

  function automatic logic [DriveW-1:0] clamp_drive(input longint v);
    if (v < 0) return '0;
    if (v > longint'(lfpd_pkg::DriveMax)) return lfpd_pkg::DriveMax;
    return v[DriveW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int ln, rn, err, diff, deriv;
    longint corr, base;
    drive_pair_t exp_beat;
    if (!rst_ni) begin
      drive_q.delete();
      white_l <= lfpd_pkg::WhiteReset; black_l <= lfpd_pkg::BlackReset;
      white_r <= lfpd_pkg::WhiteReset; black_r <= lfpd_pkg::BlackReset;
      kp <= lfpd_pkg::KpReset; kd <= lfpd_pkg::KdReset; cruise <= lfpd_pkg::CruiseReset;
      last_seen_err <= '0; last_err <= '0; last_diff <= '0;
      errors_o = 0;
      lost_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lfpd_pkg::CFG_WHITE_L: white_l <= cfg_data_i[LevelW-1:0];
          lfpd_pkg::CFG_BLACK_L: black_l <= cfg_data_i[LevelW-1:0];
          lfpd_pkg::CFG_WHITE_R: white_r <= cfg_data_i[LevelW-1:0];
          lfpd_pkg::CFG_BLACK_R: black_r <= cfg_data_i[LevelW-1:0];
          lfpd_pkg::CFG_KP:      kp      <= cfg_data_i[GainW-1:0];
          lfpd_pkg::CFG_KD:      kd      <= cfg_data_i[GainW-1:0];
          lfpd_pkg::CFG_CRUISE:  cruise  <= cfg_data_i[DriveW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          report("drive beat with nothing expected");
        end else begin
          exp_beat = drive_q.pop_front();
          if (left_drive_i !== exp_beat.left)
            report($sformatf("drive mismatch on left: got %0d, want %0d",
                             int'(left_drive_i), int'(exp_beat.left)));
          if (right_drive_i !== exp_beat.right)
            report($sformatf("drive mismatch on right: got %0d, want %0d",
                             int'(right_drive_i), int'(exp_beat.right)));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        ln  = norm_side(left_sample_i, white_l, black_l);
        rn  = norm_side(right_sample_i, white_r, black_r);
        err = ln - rn;
        // line lost: steer back toward the side it was last seen on
        if (ln < 300 && rn < 300) begin
          err = (last_seen_err > 0) ? 700 : -700;
          lost_count_o++;
        end else begin
          last_seen_err <= ErrW'(err);
        end
        diff  = err - int'(last_err);
        deriv = (diff + int'(last_diff)) / 2;
        last_diff <= ErrW'(diff);
        last_err  <= ErrW'(err);
        corr = longint'(err) * longint'(kp) + longint'(deriv) * longint'(kd);
        base = longint'(cruise);
        if (corr > 0) begin
          exp_beat.left  = clamp_drive(base - corr);
          exp_beat.right = clamp_drive(base);
        end else begin
          exp_beat.left  = clamp_drive(base);
          exp_beat.right = clamp_drive(base + corr);
        end
        drive_q.push_back(exp_beat);
      end
    end
  end
endmodule

[test/tb_line_follow_pd_steering_core.sv]
// Testbench top for the steering core: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb_line_follow_pd_steering_core;
  localparam int unsigned CfgIdxW  = lfpd_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = lfpd_pkg::CfgDataW;
  localparam int unsigned DriveW   = lfpd_pkg::DriveW;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned SettleCycles = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [SampleBits-1:0] left_sample_i = '0;
  logic [SampleBits-1:0] right_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [DriveW-1:0]     left_drive_o, right_drive_o;

  int  pending, errors, lost_count;
  int  items_sent = 0;
  int  cfg_writes = 0;
  bit  no_idle = 1'b0;   // set for a long stretch with no gaps on either side

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  line_follow_pd_steering_core #(.SAMPLE_BITS(SampleBits)) dut (.*);

  lfpd_scoreboard #(.SAMPLE_BITS(SampleBits)) u_scoreboard (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .left_sample_i, .right_sample_i,
    .out_valid_i(out_valid_o), .out_stall_i, .left_drive_i(left_drive_o),
    .right_drive_i(right_drive_o), .pending_o(pending), .errors_o(errors),
    .lost_count_o(lost_count)
  );

  // Receiver side: stall with a chance of 8 in a hundred, drawn anew at each falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 8);
  end

  // One config beat; the ready line is read just before the rising edge.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    bit ok;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      #3 ok = cfg_ready_o;
      @(posedge clk_i);
      if (!ok) @(negedge clk_i);
    end while (!ok);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // One sample beat; valid stays up back to back unless a gap is drawn.
  task automatic send_pair(input logic [SampleBits-1:0] l, input logic [SampleBits-1:0] r);
    bit ok;
    @(negedge clk_i);
    while (!no_idle && ($urandom_range(99) < 8)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    do begin
      #3 ok = !in_stall_o;
      @(posedge clk_i);
      if (!ok) @(negedge clk_i);
    end while (!ok);
    items_sent++;
  endtask

  // Drop valid, let all drive beats come back, then let the core go quiet.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_levels(input int wl, input int bl, input int wr, input int br);
    cfg_write(lfpd_pkg::CFG_WHITE_L, CfgDataW'(wl));
    cfg_write(lfpd_pkg::CFG_BLACK_L, CfgDataW'(bl));
    cfg_write(lfpd_pkg::CFG_WHITE_R, CfgDataW'(wr));
    cfg_write(lfpd_pkg::CFG_BLACK_R, CfgDataW'(br));
  endtask

  task automatic set_pd(input int p, input int d, input int cruise);
    cfg_write(lfpd_pkg::CFG_KP, CfgDataW'(p));
    cfg_write(lfpd_pkg::CFG_KD, CfgDataW'(d));
    cfg_write(lfpd_pkg::CFG_CRUISE, CfgDataW'(cruise));
  endtask

  // A raw sample aimed between the levels of one side, shifted back up to
  // twelve bits with random low bits; now and then anything at all.
  function automatic logic [SampleBits-1:0] pick_sample(input int white, input int black);
    int lo, hi;
    if ($urandom_range(99) < 20) return SampleBits'($urandom);
    lo = (white < black) ? white : black;
    hi = (white < black) ? black : white;
    lo = (lo > 40) ? lo - 40 : 0;
    hi = (hi < 983) ? hi + 40 : 1023;
    return SampleBits'(($urandom_range(hi, lo) << 2) | $urandom_range(3));
  endfunction

  initial begin
    int wl, bl, wr, br, n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);

    // Directed, reset config: lost line with no history steers to -700,
    // then full-scale samples on each side and both.
    send_pair('0, '0);
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair('1, '1);
    send_pair(SampleBits'(12'h003), SampleBits'(12'hffc));
    send_pair('0, '0);                      // lost again, last error negative
    send_pair('1, '0);
    send_pair('0, '0);                      // lost, last error positive
    drain();

    // Equal levels on both sides: every sample normalizes to zero.
    set_levels(512, 512, 1023, 1023);
    set_pd(1023, 1023, 0);
    send_pair('1, '0);
    send_pair('0, '1);
    drain();

    // Inverted levels, highest gains, cruise above the drive limit.
    set_levels(1023, 0, 900, 100);
    set_pd(1023, 1023, 32767);
    send_pair('0, '1);
    send_pair('1, '0);
    send_pair(SampleBits'(2000), SampleBits'(3000));
    send_pair('1, '1);
    drain();

    // Zero gains, wide data with upper bits set, and the unused index.
    set_levels(15'h7c00, 15'h7fff, 15'h7c00, 15'h7fff);
    set_pd(15'h7c00, 15'h7c00, 30000);
    cfg_write({CfgIdxW{1'b1}}, '1);
    send_pair(SampleBits'(4000), SampleBits'(100));
    send_pair(SampleBits'(100), SampleBits'(4000));
    drain();

    // Random phases: fresh config, then a run of samples around the levels.
    for (int ph = 0; ph < 12; ph++) begin
      no_idle = (ph == 5);
      wl = $urandom_range(400); bl = $urandom_range(1023, 600);
      wr = $urandom_range(400); br = $urandom_range(1023, 600);
      if (ph % 4 == 3) begin
        wl = $urandom_range(1023); bl = $urandom_range(1023);
        wr = $urandom_range(1023); br = $urandom_range(1023);
      end
      set_levels(wl | ($urandom_range(31) << 10), bl, wr, br | ($urandom_range(31) << 10));
      case (ph % 3)
        0: set_pd($urandom_range(40), $urandom_range(40), $urandom_range(30000));
        1: set_pd($urandom_range(1023), $urandom_range(1023), $urandom_range(32767));
        default: set_pd(ph[0] ? 0 : 1023, ph[1] ? 1023 : 0, ph[0] ? 0 : 32767);
      endcase
      n = 100;
      for (int k = 0; k < n; k++) begin
        send_pair(pick_sample(wl, bl), pick_sample(wr, br));
      end
      drain();
    end
    no_idle = 1'b0;

    $display("Covered %0d sample beats over %0d config writes, %0d of them with the line lost.",
             items_sent, cfg_writes, lost_count);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: allow several times the length of the slowest run.
  initial begin
    #6ms;
    $display("Timed out with %0d drive beats outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
